// ----- rtl/fss_pkg.sv -----
// fss_pkg: shared types, constants and helpers for the fuzzy subsequence scorer
// no dependencies; used by fss_if.sv and fuzzy_subsequence_scorer.sv
package fss_pkg;

  localparam int NEEDLE_WORDS = 4;
  localparam int WORD_W       = 64;
  localparam int NEEDLE_BYTES = NEEDLE_WORDS * WORD_W / 8;
  localparam int NBYTE_IDX_W  = $clog2(NEEDLE_BYTES);
  localparam int LEN_W        = 6;
  localparam int SCORE_W      = 12;
  localparam int CFG_IDX_W    = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LEN = 3'd4;

  // result kinds
  localparam logic KIND_HIT     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // scoring
  localparam logic [SCORE_W-1:0] BONUS_WORD  = 12'd12;
  localparam logic [SCORE_W-1:0] BONUS_PLAIN = 12'd3;

  // word separators and case folding bounds
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  typedef struct packed {
    logic                      result_kind;
    logic [7:0]                hit_position;
    logic                      matched;
    logic signed [SCORE_W-1:0] score;
    logic                      last_result;
  } result_t;

  // ascii upper case to lower case, other bytes unchanged
  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = c + CASE_DELTA;
    end
    return r;
  endfunction

endpackage

// ----- rtl/fss_if.sv -----
// fss_if: valid/ready channel interfaces for haystack bytes and results
// depends on fss_pkg
interface fss_in_if;
  logic       valid;
  logic       ready;
  logic       char_present;
  logic [7:0] haystack_char;
  logic       end_of_haystack;

  modport source (output valid, char_present, haystack_char, end_of_haystack, input ready);
  modport sink (input valid, char_present, haystack_char, end_of_haystack, output ready);
endinterface

interface fss_out_if import fss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      result_kind;
  logic [7:0]                hit_position;
  logic                      matched;
  logic signed [SCORE_W-1:0] score;
  logic                      last_result;

  modport source (output valid, result_kind, hit_position, matched, score, last_result,
                  input ready);
  modport sink (input valid, result_kind, hit_position, matched, score, last_result,
                output ready);
endinterface

// ----- rtl/fuzzy_subsequence_scorer.sv -----
// fuzzy_subsequence_scorer: streaming needle-in-haystack subsequence scorer
// depends on fss_pkg and the channel interfaces in fss_if.sv
// The scorer takes one haystack byte per clock cycle while its output queue has
// room. Each accepted transaction is scored in the cycle it is accepted and its
// results (a hit report, a verdict, both or neither) go into a four-entry output
// queue that drains one result per cycle while the sink is ready. Input ready is
// high while the queue holds two results or fewer; an end transaction that is also
// a hit emits two results. The user must load the needle through the write port
// only while the block is idle; the block does not enforce it. The haystack length
// count saturates at MAX_HAYSTACK and hit positions report its low eight bits.
module fuzzy_subsequence_scorer import fss_pkg::*; #(
  parameter int MAX_NEEDLE   = 32,
  parameter int MAX_HAYSTACK = 255
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata,
  fss_in_if.sink               in_ch,
  fss_out_if.source            out_ch
);

  localparam int POS_W  = $clog2(MAX_HAYSTACK + 1);
  localparam int PROG_W = $clog2(MAX_NEEDLE + 1);
  localparam int DIFF_W = ((POS_W > SCORE_W) ? POS_W : SCORE_W) + 1;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [LEN_W-1:0]   MAX_LEN = LEN_W'(MAX_NEEDLE);
  localparam logic [POS_W-1:0]   POS_MAX = POS_W'(MAX_HAYSTACK);
  localparam logic [Q_CNT_W-1:0] Q_ROOM  = Q_CNT_W'(Q_DEPTH - 2);
  localparam logic signed [DIFF_W-1:0] SC_MIN = DIFF_W'(-(2 ** (SCORE_W - 1)));
  localparam logic signed [DIFF_W-1:0] SC_MAX = DIFF_W'(2 ** (SCORE_W - 1) - 1);

  // configuration registers
  logic [NEEDLE_WORDS-1:0][WORD_W-1:0] needle_regs;
  logic [NEEDLE_BYTES-1:0][7:0]        needle_flat;
  logic [LEN_W-1:0]                    needle_length;

  // per-haystack state
  logic [POS_W-1:0]   haystack_position, haystack_position_next;
  logic [PROG_W-1:0]  needle_progress, needle_progress_next;
  logic [PROG_W-1:0]  run_length, run_length_next;
  logic [SCORE_W-1:0] score_sum, score_sum_next;
  logic [7:0]         previous_char, previous_char_next;

  // output queue
  result_t              q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   q_wr_ptr, q_rd_ptr;
  logic [Q_CNT_W-1:0]   q_count;

  logic accept, pop;
  logic [LEN_W-1:0] len_act;
  logic [NBYTE_IDX_W-1:0] nb_idx;
  logic [7:0] needle_byte;
  logic pending, hit, at_boundary;
  logic [PROG_W-1:0] run_inc;
  logic signed [DIFF_W-1:0] diff;
  result_t hit_res, verdict_res;

  assign accept = in_ch.valid && in_ch.ready;
  assign pop    = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (q_count <= Q_ROOM);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      needle_regs   <= '0;
      needle_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NEEDLE_0:   needle_regs[0] <= cfg_wdata;
        REG_NEEDLE_1:   needle_regs[1] <= cfg_wdata;
        REG_NEEDLE_2:   needle_regs[2] <= cfg_wdata;
        REG_NEEDLE_3:   needle_regs[3] <= cfg_wdata;
        REG_NEEDLE_LEN: needle_length  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign needle_flat = needle_regs;
  assign len_act     = (needle_length > MAX_LEN) ? MAX_LEN : needle_length;
  assign nb_idx      = NBYTE_IDX_W'(needle_progress);
  assign needle_byte = needle_flat[nb_idx];

  // match and score update for the incoming byte
  always_comb begin
    pending     = LEN_W'(needle_progress) < len_act;
    hit         = in_ch.char_present && pending &&
                  (fold_byte(in_ch.haystack_char) == fold_byte(needle_byte));
    at_boundary = (haystack_position == '0) || (previous_char == CH_SPACE) ||
                  (previous_char == CH_GT) || (previous_char == CH_DASH);
    run_inc     = run_length + PROG_W'(1);

    haystack_position_next = haystack_position;
    needle_progress_next   = needle_progress;
    run_length_next        = run_length;
    score_sum_next         = score_sum;
    previous_char_next     = previous_char;

    if (in_ch.char_present) begin
      if (hit) begin
        needle_progress_next = needle_progress + PROG_W'(1);
        run_length_next      = run_inc;
        score_sum_next       = score_sum + (at_boundary ? BONUS_WORD : BONUS_PLAIN) +
                               (SCORE_W'(run_inc) << 1);
      end else if (pending) begin
        run_length_next = '0;
      end
      previous_char_next = in_ch.haystack_char;
      if (haystack_position < POS_MAX) begin
        haystack_position_next = haystack_position + POS_W'(1);
      end
    end
  end

  // result items
  always_comb begin
    diff = $signed(DIFF_W'(score_sum_next)) - $signed(DIFF_W'(haystack_position_next >> 3));

    hit_res.result_kind  = KIND_HIT;
    hit_res.hit_position = 8'(haystack_position);
    hit_res.matched      = 1'b0;
    hit_res.score        = '0;
    hit_res.last_result  = 1'b0;

    verdict_res.result_kind  = KIND_VERDICT;
    verdict_res.hit_position = '0;
    verdict_res.matched      = 1'b1;
    verdict_res.score        = '0;
    verdict_res.last_result  = 1'b1;
    priority if (len_act == '0) begin
      verdict_res.matched = 1'b1;
    end else if (LEN_W'(needle_progress_next) >= len_act) begin
      if (diff < SC_MIN) begin
        verdict_res.score = SCORE_W'(SC_MIN);
      end else if (diff > SC_MAX) begin
        verdict_res.score = SCORE_W'(SC_MAX);
      end else begin
        verdict_res.score = SCORE_W'(diff);
      end
    end else begin
      verdict_res.matched = 1'b0;
    end
  end

  // state registers, cleared after each verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      haystack_position <= '0;
      needle_progress   <= '0;
      run_length        <= '0;
      score_sum         <= '0;
      previous_char     <= '0;
    end else if (accept) begin
      if (in_ch.end_of_haystack) begin
        haystack_position <= '0;
        needle_progress   <= '0;
        run_length        <= '0;
        score_sum         <= '0;
        previous_char     <= '0;
      end else begin
        haystack_position <= haystack_position_next;
        needle_progress   <= needle_progress_next;
        run_length        <= run_length_next;
        score_sum         <= score_sum_next;
        previous_char     <= previous_char_next;
      end
    end
  end

  // output queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      if (hit) begin
        q_mem[q_wr_ptr] <= hit_res;
      end
      if (in_ch.end_of_haystack) begin
        q_mem[q_wr_ptr + Q_PTR_W'(hit)] <= verdict_res;
      end
    end
  end

  // output queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr_ptr <= '0;
      q_rd_ptr <= '0;
      q_count  <= '0;
    end else begin
      if (accept) begin
        q_wr_ptr <= q_wr_ptr + Q_PTR_W'(hit) + Q_PTR_W'(in_ch.end_of_haystack);
      end
      if (pop) begin
        q_rd_ptr <= q_rd_ptr + Q_PTR_W'(1);
      end
      q_count <= q_count + (accept ? (Q_CNT_W'(hit) + Q_CNT_W'(in_ch.end_of_haystack)) : '0)
                 - Q_CNT_W'(pop);
    end
  end

  // output channel
  assign out_ch.valid        = (q_count != '0);
  assign out_ch.result_kind  = q_mem[q_rd_ptr].result_kind;
  assign out_ch.hit_position = q_mem[q_rd_ptr].hit_position;
  assign out_ch.matched      = q_mem[q_rd_ptr].matched;
  assign out_ch.score        = q_mem[q_rd_ptr].score;
  assign out_ch.last_result  = q_mem[q_rd_ptr].last_result;

  // queue never overfills
  assert property (@(posedge clk) disable iff (rst) q_count <= Q_CNT_W'(Q_DEPTH))
    else $error("output queue overflow");

  // a verdict clears the per-haystack state
  assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.end_of_haystack |=> needle_progress == '0 && haystack_position == '0)
    else $error("state not cleared after verdict");

  // a hit that does not close the haystack advances the needle by one
  assert property (@(posedge clk) disable iff (rst)
    accept && hit && !in_ch.end_of_haystack |=>
      needle_progress == $past(needle_progress) + PROG_W'(1))
    else $error("needle progress did not advance on hit");

  // progress never runs past the active needle length while a haystack is open
  assert property (@(posedge clk) disable iff (rst)
    accept && !in_ch.end_of_haystack && !cfg_we |=>
      LEN_W'(needle_progress) <= len_act || $past(LEN_W'(needle_progress) > len_act))
    else $error("needle progress beyond needle length");

endmodule

// ----- sim/tb_top.sv -----
// tb_top: self-checking testbench for the fuzzy subsequence scorer
// depends on fss_pkg, the channel interfaces in fss_if.sv and fuzzy_subsequence_scorer
// a scoreboard class predicts hit reports and verdicts per haystack byte and checks them
`timescale 1ns / 100ps

module tb_top import fss_pkg::*; ();

  localparam int ITEM_TARGET   = 1350;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_GAP       = 16;

  localparam logic [7:0] CH_LOWER_A = "a";
  localparam logic [7:0] CH_LOWER_Z = "z";
  localparam logic [7:0] WORD_BREAKS [3] = '{CH_SPACE, CH_GT, CH_DASH};
  localparam logic [CFG_IDX_W-1:0] NEEDLE_REGS [4] =
    '{REG_NEEDLE_0, REG_NEEDLE_1, REG_NEEDLE_2, REG_NEEDLE_3};

  typedef enum int {HAY_CLEAN, HAY_BROKEN, HAY_NOISE, HAY_EMPTY, HAY_LONG} hay_shape_e;

  // predicts the scorer's results and checks what it emits
  class match_scoreboard;
    result_t     pending_reports[$];
    logic [63:0] needle_word [4];
    logic [5:0]  needle_len;
    logic [7:0]  hay_pos;
    logic [5:0]  progress;
    logic [5:0]  run_len;
    int          bonus_sum;
    logic [7:0]  prev_char;
    int unsigned n_errors;
    int unsigned n_inputs;
    int unsigned n_hits;
    int unsigned n_verdicts;
    int unsigned n_matched;

    function new();
      foreach (needle_word[i]) needle_word[i] = '0;
      needle_len = '0;
      clear_haystack();
      n_errors = 0;
      n_inputs = 0;
      n_hits = 0;
      n_verdicts = 0;
      n_matched = 0;
    endfunction

    function void clear_haystack();
      hay_pos = '0;
      progress = '0;
      run_len = '0;
      bonus_sum = 0;
      prev_char = '0;
    endfunction

    function logic [7:0] lower_case(logic [7:0] c);
      if (c >= "A" && c <= "Z") begin
        return c + 8'h20;
      end
      return c;
    endfunction

    function void load_register(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      case (idx)
        REG_NEEDLE_0: needle_word[0] = data;
        REG_NEEDLE_1: needle_word[1] = data;
        REG_NEEDLE_2: needle_word[2] = data;
        REG_NEEDLE_3: needle_word[3] = data;
        REG_NEEDLE_LEN: needle_len = data[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted haystack transaction: update the match state, queue its results
    function void score_transaction(logic present, logic [7:0] ch, logic last);
      logic [5:0]  eff_len;
      logic [7:0]  want_byte;
      logic        at_boundary;
      result_t     r;
      int          sc;
      n_inputs++;
      eff_len = (needle_len > 6'd32) ? 6'd32 : needle_len;
      if (present) begin
        if (progress < eff_len) begin
          want_byte = needle_word[progress[4:3]][progress[2:0]*8 +: 8];
          if (lower_case(ch) == lower_case(want_byte)) begin
            at_boundary = (hay_pos == 0) || prev_char == CH_SPACE ||
                          prev_char == CH_GT || prev_char == CH_DASH;
            bonus_sum += at_boundary ? int'(BONUS_WORD) : int'(BONUS_PLAIN);
            run_len = run_len + 1'b1;
            bonus_sum += 2 * int'(run_len);
            progress = progress + 1'b1;
            r = '0;
            r.result_kind = KIND_HIT;
            r.hit_position = hay_pos;
            pending_reports.insert(pending_reports.size(), r);
          end else begin
            run_len = '0;
          end
        end
        prev_char = ch;
        if (hay_pos != 8'hFF) hay_pos = hay_pos + 1'b1;
      end
      if (last) begin
        r = '0;
        r.result_kind = KIND_VERDICT;
        r.matched = 1'b1;
        r.last_result = 1'b1;
        sc = 0;
        if (eff_len != 0) begin
          if (progress >= eff_len) begin
            sc = bonus_sum - int'(hay_pos) / 8;
            if (sc < -2048) sc = -2048;
            if (sc > 2047) sc = 2047;
          end else begin
            r.matched = 1'b0;
          end
        end
        r.score = sc[SCORE_W-1:0];
        pending_reports.insert(pending_reports.size(), r);
        clear_haystack();
      end
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        n_errors++;
      end
    endfunction

    function void check_report(result_t seen);
      result_t want;
      if (pending_reports.size() == 0) begin
        $error("result with nothing awaited: kind %0d, position %0d",
               seen.result_kind, seen.hit_position);
        n_errors++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("result_kind", want.result_kind, seen.result_kind);
      compare_field("hit_position", want.hit_position, seen.hit_position);
      compare_field("matched", want.matched, seen.matched);
      compare_field("score", want.score, seen.score);
      compare_field("last_result", want.last_result, seen.last_result);
      if (want.result_kind == KIND_HIT) begin
        n_hits++;
      end else begin
        n_verdicts++;
        if (want.matched) n_matched++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_wdata;

  fss_in_if  in_ch ();
  fss_out_if out_ch ();

  fuzzy_subsequence_scorer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  match_scoreboard board = new();

  // stimulus-side copy of the needle, used to build haystacks
  logic [63:0] stim_needle [4];
  logic [5:0]  stim_len;
  logic [7:0]  hay_bytes[$];
  int          sent_items;
  int          src_mode;
  int          snk_mode;
  int          settings_used;
  bit          hold_request;
  int          cycle_count = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // watch register writes and both channels
  always @(posedge clk) begin
    if (!rst && cfg_we) begin
      board.load_register(cfg_index, cfg_wdata);
    end
    if (!rst && in_ch.valid && in_ch.ready) begin
      board.score_transaction(in_ch.char_present, in_ch.haystack_char, in_ch.end_of_haystack);
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      board.check_report({out_ch.result_kind, out_ch.hit_position, out_ch.matched,
                          out_ch.score, out_ch.last_result});
    end
  end

  // idle cycles before a transaction: mode 0 none, 1 occasional, 2 any
  function automatic int draw_gap(int mode);
    if (mode == 0) return 0;
    if (mode == 1) return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_GAP) : 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] c);
    if ($urandom_range(0, 1) == 0) return c;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return c - CASE_DELTA;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return c + CASE_DELTA;
    return c;
  endfunction

  function automatic logic [7:0] pick_needle_byte();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 11) return flip_case(CH_LOWER_A + 8'($urandom_range(0, 7)));
    if (sel < 14) return WORD_BREAKS[$urandom_range(0, 2)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_filler();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 10) return flip_case(CH_LOWER_A + 8'($urandom_range(0, 25)));
    if (sel < 14) return WORD_BREAKS[$urandom_range(0, 2)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic hay_shape_e draw_shape();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 12 || sel == 19) return HAY_CLEAN;
    if (sel < 15) return HAY_BROKEN;
    if (sel < 18) return HAY_NOISE;
    return HAY_EMPTY;
  endfunction

  // register write at the next edge; cfg_we is lowered by end_writes
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == REG_NEEDLE_LEN) begin
      stim_len = data[LEN_W-1:0];
    end else begin
      stim_needle[idx] = data;
    end
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
  endtask

  // one input transaction, held until accepted
  task automatic send_item(logic present, logic [7:0] ch, logic last);
    int gap;
    gap = draw_gap(src_mode);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_present <= present;
    in_ch.haystack_char <= ch;
    in_ch.end_of_haystack <= last;
    if (present || last) sent_items++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering and wait until every awaited result has come out
  task automatic stop_and_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_needle_text(string text, logic [5:0] len);
    logic [63:0] w;
    w = '0;
    for (int i = 0; i < text.len(); i++) w[i*8 +: 8] = text[i];
    write_reg(REG_NEEDLE_0, w);
    write_reg(REG_NEEDLE_LEN, {58'd0, len});
    end_writes();
    settings_used++;
  endtask

  task automatic send_text(string text);
    for (int i = 0; i < text.len(); i++) send_item(1'b1, text[i], i == text.len() - 1);
  endtask

  task automatic build_haystack(hay_shape_e shape);
    int n;
    int cut;
    logic [5:0] j6;
    hay_bytes.delete();
    n = (stim_len > 6'd32) ? 32 : int'(stim_len);
    cut = (shape == HAY_BROKEN && n > 0) ? $urandom_range(0, n - 1) : n;
    case (shape)
      HAY_NOISE: begin
        repeat ($urandom_range(1, 16))
          hay_bytes.insert(hay_bytes.size(), 8'($urandom_range(0, 255)));
      end
      HAY_EMPTY: ;
      default: begin
        // long haystacks put the needle near or past the saturation point
        if (shape == HAY_LONG)
          repeat ($urandom_range(250, 262)) hay_bytes.insert(hay_bytes.size(), pick_filler());
        for (int j = 0; j < cut; j++) begin
          j6 = 6'(j);
          if ($urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, 3)) hay_bytes.insert(hay_bytes.size(), pick_filler());
          end
          hay_bytes.insert(hay_bytes.size(), flip_case(stim_needle[j6[4:3]][j6[2:0]*8 +: 8]));
        end
        repeat ($urandom_range(0, 3)) hay_bytes.insert(hay_bytes.size(), pick_filler());
      end
    endcase
  endtask

  // sends hay_bytes, sometimes with ignored transactions or a separate end mark
  task automatic send_haystack();
    bit split_end;
    split_end = (hay_bytes.size() == 0) || ($urandom_range(0, 5) == 0);
    foreach (hay_bytes[i]) begin
      if ($urandom_range(0, 19) == 0) send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
      send_item(1'b1, hay_bytes[i], !split_end && i == hay_bytes.size() - 1);
    end
    if (split_end) send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  // new needle for a phase; the first few phases pin the extremes
  task automatic configure_phase(int phase);
    logic [63:0] w;
    logic [5:0]  len;
    for (int i = 0; i < 4; i++) begin
      if (phase == 3) begin
        w = '1;
      end else if (phase == 4) begin
        w = '0;
      end else begin
        for (int b = 0; b < 8; b++) w[b*8 +: 8] = pick_needle_byte();
      end
      write_reg(NEEDLE_REGS[i], w);
    end
    case (phase)
      0: len = 6'd6;
      1: len = 6'd32;
      2: len = 6'd0;
      3: len = 6'd32;
      4: len = 6'd33;
      5: len = 6'd63;
      default: len = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(13, 40))
                                                   : 6'($urandom_range(1, 12));
    endcase
    w = {$urandom, $urandom};
    w[LEN_W-1:0] = len;
    write_reg(REG_NEEDLE_LEN, w);
    end_writes();
    settings_used++;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int w;
    bit hold_taken;
    hold_taken = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        w = LONG_HOLD;
      end else begin
        w = draw_gap(snk_mode);
      end
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // main sequence
  initial begin
    int phase;
    int hay_count;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_NEEDLE_0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.char_present <= 1'b0;
    in_ch.haystack_char <= '0;
    in_ch.end_of_haystack <= 1'b0;
    foreach (stim_needle[i]) stim_needle[i] = '0;
    stim_len = '0;
    sent_items = 0;
    settings_used = 0;
    hold_request = 1'b0;
    src_mode = 2;
    snk_mode = 2;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty needle after reset: ignored item, one byte, then an empty haystack
    send_item(1'b0, 8'hA5, 1'b0);
    send_item(1'b1, "x", 1'b1);
    send_item(1'b0, 8'h5A, 1'b1);
    stop_and_drain();

    // word starts at position 0, after '>' and '-'; case folding; bytes after completion
    set_needle_text("fO-b", 6'd4);
    send_text("Fo>-Bz");
    stop_and_drain();

    // word start after a space, then the length drops below progress mid-haystack
    set_needle_text("xyz", 6'd3);
    send_item(1'b1, CH_SPACE, 1'b0);
    send_item(1'b1, "X", 1'b0);
    send_item(1'b1, "y", 1'b0);
    stop_and_drain();
    write_reg(REG_NEEDLE_LEN, 64'd1);
    end_writes();
    send_item(1'b1, "z", 1'b1);
    stop_and_drain();

    // bytes next to the letter ranges are not folded; oversize length
    set_needle_text("@[`{", 6'd40);
    send_item(1'b1, 8'h40, 1'b0);
    send_item(1'b1, 8'h5B, 1'b0);
    send_item(1'b1, 8'h7B, 1'b0);
    send_item(1'b1, 8'h60, 1'b0);
    send_item(1'b1, 8'hC1, 1'b1);
    stop_and_drain();

    // run bonus on adjacent upper-case matches at the edges of the alphabet
    set_needle_text("az", 6'd2);
    send_text("AZ");

    // random phases
    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      stop_and_drain();
      configure_phase(phase);
      src_mode = (phase == 0) ? 0 : $urandom_range(0, 2);
      snk_mode = $urandom_range(0, 2);
      if (phase == 0) hold_request = 1'b1;
      hay_count = (stim_len > 6'd16) ? 3 : 8;
      for (int h = 0; h < hay_count; h++) begin
        if ((phase == 0 && h == 5) || (phase >= 6 && phase % 4 == 1 && h == 3)) begin
          build_haystack(HAY_LONG);
        end else begin
          build_haystack(draw_shape());
        end
        send_haystack();
        if ($urandom_range(0, 7) == 0) stop_and_drain();
      end
      phase++;
    end

    // wait out every awaited result, then keep watching for stray output
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending_reports.size() != 0) @(posedge clk);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);

    $display("tb_top: %0d input transactions over %0d needle settings", board.n_inputs,
             settings_used);
    $display("tb_top: %0d hit reports and %0d verdicts (%0d matched) compared",
             board.n_hits, board.n_verdicts, board.n_matched);
    if (board.n_errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
